### rtl/rbf_pkg.sv
package rbf_pkg;

	localparam int ACTION_W = 3;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 8;
	localparam int STAT_W   = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH  = 3'd0,
		ACT_READ  = 3'd1,
		ACT_COPY  = 3'd2,
		ACT_FLUSH = 3'd3,
		ACT_TRUNC = 3'd4
	} action_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_STREAM
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // input transaction taken this cycle
		logic step;     // emit the next element of a running read or copy
		logic load;     // load the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic multi;      // incoming read or copy yields more than one element
		logic last_elem;  // element being emitted now ends the stream
	} dp_stat_t;

endpackage

### rtl/ring_buffer_fifo.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  action, write_data, count
// out      out_valid / out_stall read_data, data_valid, last, done_count,
//                               occupancy, free_space, is_full, is_empty
//
// Push, flush, truncate and idle actions give one result each: a new transaction
// is accepted every cycle while the output register is free or being taken.
// A read or copy of n elements emits one element per unstalled cycle from the slot
// memory (registered read port) and stalls the input until the last is emitted.
// arst_n clears both pointers and the controller; slot contents are not reset.
// A stall on the output holds the current result and stalls the input.
module ring_buffer_fifo
	import rbf_pkg::*;
#(
	parameter int DEPTH         = 16,
	parameter int ELEMENT_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [DATA_W-1:0]   write_data,
	input  logic [COUNT_W-1:0]  count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DATA_W-1:0]   read_data,
	output logic                data_valid,
	output logic                last,
	output logic [STAT_W-1:0]   done_count,
	output logic [STAT_W-1:0]   occupancy,
	output logic [STAT_W-1:0]   free_space,
	output logic                is_full,
	output logic                is_empty
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rbf_dp #(
		.DEPTH         (DEPTH),
		.ELEMENT_BYTES (ELEMENT_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.write_data (write_data),
		.count      (count),
		.read_data  (read_data),
		.data_valid (data_valid),
		.last       (last),
		.done_count (done_count),
		.occupancy  (occupancy),
		.free_space (free_space),
		.is_full    (is_full),
		.is_empty   (is_empty)
	);

endmodule

### rtl/rbf_ctrl.sv
module rbf_ctrl
	import rbf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = !slot_free;
				cmd.accept = in_valid && slot_free;
				if (cmd.accept && stat.multi) begin
					state_d = ST_STREAM;
				end
			end
			ST_STREAM: begin
				cmd.step = slot_free;
				if (cmd.step && stat.last_elem) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.load = cmd.accept || cmd.step;
		// hold a result until taken, drop the flag once it is taken
		if (cmd.load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && out_stall) begin
			out_valid_d = 1'b1;
		end else begin
			out_valid_d = 1'b0;
		end
	end

endmodule

### rtl/rbf_dp.sv
module rbf_dp
	import rbf_pkg::*;
#(
	parameter int DEPTH         = 16,
	parameter int ELEMENT_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	input  logic [ACTION_W-1:0] action,
	input  logic [DATA_W-1:0]   write_data,
	input  logic [COUNT_W-1:0]  count,
	output logic [DATA_W-1:0]   read_data,
	output logic                data_valid,
	output logic                last,
	output logic [STAT_W-1:0]   done_count,
	output logic [STAT_W-1:0]   occupancy,
	output logic [STAT_W-1:0]   free_space,
	output logic                is_full,
	output logic                is_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int EW = (ELEMENT_BYTES >= 4) ? DATA_W : 8 * ELEMENT_BYTES;
	localparam int XW = PW + STAT_W;
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(DEPTH);

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] held(input logic [PW-1:0] rp, input logic [PW-1:0] wp);
		logic [PW:0] diff;
		diff = {1'b0, wp} - {1'b0, rp};
		if (wp < rp) begin
			diff = diff + DEPTH_X;
		end
		return diff[PW-1:0];
	endfunction

	logic [EW-1:0]     mem [DEPTH];
	logic [PW-1:0]     rp_q, wp_q, rp_d, wp_d;
	logic [PW-1:0]     ptr_q, remain_q;
	logic [EW-1:0]     rdata_q;
	logic              dv_q, last_q, full_q, empty_q;
	logic [STAT_W-1:0] done_q, occ_q, free_q;

	action_t           act;
	logic [PW-1:0]     occ, n, adv, done, occ_n, raddr;
	logic [PW:0]       adv_sum;
	logic [COUNT_W-1:0] occ_c;
	logic              full_now, do_push, elem_rd, is_rd, single_last, last_d;
	logic [XW-1:0]     done_x, occ_x, free_x;

	assign act      = action_t'(action);
	assign occ      = held(rp_q, wp_q);
	assign occ_c    = COUNT_W'(occ);
	assign full_now = (inc(wp_q) == rp_q);
	assign n        = (count < occ_c) ? PW'(count) : occ;
	assign is_rd    = (act == ACT_READ) || (act == ACT_COPY);
	assign do_push  = cmd.accept && (act == ACT_PUSH) && !full_now;

	// one modular adder serves read-consume and partial flush
	assign adv     = (act == ACT_FLUSH) ? PW'(count) : n;
	assign adv_sum = {1'b0, rp_q} + {1'b0, adv};

	always_comb begin
		rp_d = rp_q;
		wp_d = wp_q;
		done = '0;
		if (cmd.accept) begin
			unique case (act)
				ACT_PUSH: begin
					if (!full_now) begin
						wp_d = inc(wp_q);
						done = PW'(1);
					end
				end
				ACT_READ, ACT_COPY: begin
					done = n;
					if (act == ACT_READ) begin
						rp_d = (adv_sum >= DEPTH_X) ? PW'(adv_sum - DEPTH_X) : adv_sum[PW-1:0];
					end
				end
				ACT_FLUSH: begin
					if (count >= occ_c) begin
						rp_d = '0;
						wp_d = '0;
						done = occ;
					end else begin
						rp_d = (adv_sum >= DEPTH_X) ? PW'(adv_sum - DEPTH_X) : adv_sum[PW-1:0];
						done = PW'(count);
					end
				end
				ACT_TRUNC: begin
					if (occ != '0) begin
						wp_d = (wp_q == '0) ? LAST_IDX : wp_q - 1'b1;
						done = PW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign occ_n  = held(rp_d, wp_d);
	assign done_x = XW'(done);
	assign occ_x  = XW'(occ_n);
	assign free_x = XW'(LAST_IDX - occ_n);

	assign elem_rd     = cmd.step || (cmd.accept && is_rd && (n != '0));
	assign single_last = !(is_rd && (n > PW'(1)));
	assign last_d      = cmd.step ? (remain_q == PW'(1)) : single_last;
	assign raddr       = cmd.step ? ptr_q : rp_q;

	assign stat.multi     = is_rd && (n > PW'(1));
	assign stat.last_elem = (remain_q == PW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
		end else begin
			rp_q <= rp_d;
			wp_q <= wp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= write_data[EW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rdata_q <= elem_rd ? mem[raddr] : '0;
		end
	end

	// advance the stream address past each element sent
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ptr_q    <= inc(rp_q);
			remain_q <= n - 1'b1;
		end else if (cmd.step) begin
			ptr_q    <= inc(ptr_q);
			remain_q <= remain_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dv_q    <= elem_rd;
			last_q  <= last_d;
			occ_q   <= occ_x[STAT_W-1:0];
			free_q  <= free_x[STAT_W-1:0];
			full_q  <= (inc(wp_d) == rp_d);
			empty_q <= (rp_d == wp_d);
		end
		if (cmd.accept) begin
			done_q <= done_x[STAT_W-1:0];
		end
	end

	assign read_data  = DATA_W'(rdata_q);
	assign data_valid = dv_q;
	assign last       = last_q;
	assign done_count = done_q;
	assign occupancy  = occ_q;
	assign free_space = free_q;
	assign is_full    = full_q;
	assign is_empty   = empty_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import rbf_pkg::*;

	localparam int SLOTS       = 16;
	localparam int PTR_W       = 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 100;
	localparam int MAX_REPORTS = 60;
	localparam logic [ACTION_W-1:0] ACT_MAX = '1;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              data_valid;
		logic              last;
		logic [STAT_W-1:0] done_count;
		logic [STAT_W-1:0] occupancy;
		logic [STAT_W-1:0] free_space;
		logic              is_full;
		logic              is_empty;
	} result_t;

	// Tracks the ring contents and pointers, and the results each transaction owes.
	class fifo_tracker;
		logic [DATA_W-1:0] slots [SLOTS];
		logic [PTR_W-1:0]  rd_ptr;
		logic [PTR_W-1:0]  wr_ptr;
		result_t           due [$];
		int unsigned       errors;

		function new();
			rd_ptr = '0;
			wr_ptr = '0;
			errors = 0;
		endfunction

		function logic [PTR_W-1:0] held();
			return wr_ptr - rd_ptr;
		endfunction

		function void add_result(logic [DATA_W-1:0] data, logic valid, logic fin,
			logic [STAT_W-1:0] done);
			result_t          r;
			logic [PTR_W-1:0] h;
			logic [PTR_W-1:0] nxt;
			h   = held();
			nxt = wr_ptr + 1'b1;
			r.read_data  = data;
			r.data_valid = valid;
			r.last       = fin;
			r.done_count = done;
			r.occupancy  = h;
			r.free_space = STAT_W'(SLOTS - 1) - h;
			r.is_full    = (nxt == rd_ptr);
			r.is_empty   = (rd_ptr == wr_ptr);
			due.push_back(r);
		endfunction

		function void apply_action(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] data,
			logic [COUNT_W-1:0] cnt);
			logic [PTR_W-1:0]  h;
			logic [PTR_W-1:0]  p;
			logic [PTR_W-1:0]  nxt;
			logic [STAT_W-1:0] done;
			int unsigned       n;
			int unsigned       i;
			h    = held();
			nxt  = wr_ptr + 1'b1;
			done = '0;
			case (act)
			ACT_PUSH: begin
				// drop the element when full
				if (nxt != rd_ptr) begin
					slots[wr_ptr] = data;
					wr_ptr = nxt;
					done = 1;
				end
			end
			ACT_READ, ACT_COPY: begin
				n = (cnt < h) ? cnt : h;
				if (n != 0) begin
					p = rd_ptr;
					if (act == ACT_READ)
						rd_ptr = rd_ptr + PTR_W'(n);
					for (i = 0; i < n; i++) begin
						add_result(slots[p], 1'b1, i == n - 1, STAT_W'(n));
						p = p + 1'b1;
					end
					return;
				end
			end
			ACT_FLUSH: begin
				if (cnt >= h) begin
					rd_ptr = '0;
					wr_ptr = '0;
					done = h;
				end else begin
					rd_ptr = rd_ptr + PTR_W'(cnt);
					done = STAT_W'(cnt);
				end
			end
			ACT_TRUNC: begin
				if (h != 0) begin
					wr_ptr = wr_ptr - 1'b1;
					done = 1;
				end
			end
			default: ;
			endcase
			add_result('0, 1'b0, 1'b1, done);
		endfunction

		function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
			if (want !== got) begin
				if (errors < MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (due.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual read_data %0h",
						$time, got.read_data);
				errors++;
				return;
			end
			want = due.pop_front();
			check_field("read_data", want.read_data, got.read_data);
			check_field("data_valid", want.data_valid, got.data_valid);
			check_field("last", want.last, got.last);
			check_field("done_count", want.done_count, got.done_count);
			check_field("occupancy", want.occupancy, got.occupancy);
			check_field("free_space", want.free_space, got.free_space);
			check_field("is_full", want.is_full, got.is_full);
			check_field("is_empty", want.is_empty, got.is_empty);
		endfunction
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [ACTION_W-1:0] action     = ACT_PUSH;
	logic [DATA_W-1:0]   write_data = '0;
	logic [COUNT_W-1:0]  count      = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [DATA_W-1:0]   read_data;
	logic                data_valid;
	logic                last;
	logic [STAT_W-1:0]   done_count;
	logic [STAT_W-1:0]   occupancy;
	logic [STAT_W-1:0]   free_space;
	logic                is_full;
	logic                is_empty;

	fifo_tracker tracker;
	int unsigned burst_left = 0;

	ring_buffer_fifo #(
		.DEPTH         (SLOTS),
		.ELEMENT_BYTES (4)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.write_data (write_data),
		.count      (count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.data_valid (data_valid),
		.last       (last),
		.done_count (done_count),
		.occupancy  (occupancy),
		.free_space (free_space),
		.is_full    (is_full),
		.is_empty   (is_empty)
	);

	always #6 clk = ~clk;

	// Offer one transaction and hold it until taken; bursts with random gaps between.
	task automatic send(logic [ACTION_W-1:0] a, logic [DATA_W-1:0] d, logic [COUNT_W-1:0] c);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid   <= 1'b1;
		action     <= a;
		write_data <= d;
		count      <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.apply_action(a, d, c);
	endtask

	task automatic send_random(output bit useful);
		int unsigned        pick;
		logic [COUNT_W-1:0] c;
		pick   = $urandom_range(0, 99);
		useful = 1'b1;
		// keep most counts near the occupancy, some past it, a few anywhere
		if ($urandom_range(0, 9) < 7)
			c = COUNT_W'($urandom_range(0, 6));
		else if ($urandom_range(0, 2) != 0)
			c = COUNT_W'($urandom_range(0, 17));
		else
			c = COUNT_W'($urandom);
		if (pick < 40)
			send(ACT_PUSH, $urandom, c);
		else if (pick < 58)
			send(ACT_READ, $urandom, c);
		else if (pick < 72)
			send(ACT_COPY, $urandom, c);
		else if (pick < 82)
			send(ACT_FLUSH, $urandom, c);
		else if (pick < 92)
			send(ACT_TRUNC, $urandom, c);
		else begin
			send(ACTION_W'($urandom_range(ACT_TRUNC + 1, ACT_MAX)), $urandom, c);
			useful = 1'b0;
		end
	endtask

	// Receiver: check each taken result, stall on a shifting pattern, hold off now and then.
	initial begin : drain
		int unsigned seen;
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned stall_pct;
		int unsigned next_hold;
		logic        stall_next;
		seen      = 0;
		hold_left = 0;
		mode_left = 0;
		stall_pct = 0;
		next_hold = 25;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				tracker.match_result(result_t'{read_data, data_valid, last, done_count,
					occupancy, free_space, is_full, is_empty});
				seen++;
			end
			if (hold_left == 0 && seen >= next_hold) begin
				hold_left = 60;
				next_hold = seen + 120;
			end
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 25;
					default: stall_pct = 70;
					endcase
					mode_left = $urandom_range(5, 40);
				end
				mode_left--;
				stall_next = ($urandom_range(0, 99) < stall_pct);
			end
			out_stall <= stall_next;
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned made;
		int unsigned run;
		int unsigned i;
		bit          useful;
		logic [DATA_W-1:0] d;
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty corner cases
		send(ACT_READ, '0, 8'd5);
		send(ACT_COPY, '1, 8'd1);
		send(ACT_FLUSH, '0, 8'd0);
		send(ACT_TRUNC, '0, 8'd0);
		send(ACT_MAX, '1, '1);
		// fill to capacity, then push once more to hit the drop
		for (i = 0; i < SLOTS - 1; i++) begin
			case (i)
			0: d = '0;
			1: d = '1;
			2: d = 32'hAAAA_AAAA;
			3: d = 32'h5555_5555;
			default: d = $urandom;
			endcase
			send(ACT_PUSH, d, '0);
		end
		send(ACT_PUSH, 32'h1234_5678, '0);
		send(ACT_COPY, '0, '1);
		send(ACT_READ, '0, 8'd3);
		send(ACT_READ, '0, 8'd0);
		send(ACT_FLUSH, '0, 8'd2);
		send(ACT_TRUNC, '0, 8'd0);
		send(ACT_FLUSH, '0, '1);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				// push runs reach full often
				run = $urandom_range(4, 16);
				repeat (run) send(ACT_PUSH, $urandom, COUNT_W'($urandom));
				made += run;
			end else begin
				send_random(useful);
				if (useful)
					made++;
			end
		end
		in_valid <= 1'b0;

		while (tracker.due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
